// ===== src/bresenham_line_pixel_generator_assert.svh =====
// assertion macros for the line generator checker
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define BLPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define BLPG_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/blpg_pkg.sv =====
// shared constants for the bresenham line pixel generator
package blpg_pkg;

    localparam int DEFAULT_COORD_BITS = 12;
    localparam int DIM_BITS           = 12;
    localparam int ADDR_BITS          = 22;
    localparam int COLOR_BITS         = 32;
    localparam int CFG_INDEX_BITS     = 1;

    localparam logic [DIM_BITS-1:0] RESET_SCREEN_WIDTH  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] RESET_SCREEN_HEIGHT = DIM_BITS'(480);

    // input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

endpackage

// ===== src/bresenham_line_pixel_generator.sv =====
// Bresenham line pixel generator: one item per clock while m_ is not stalled, one pixel per step item.
// A start item (s_op = 0) loads both endpoints and the color and sets up the
// integer walk along the major axis; it gives no result. Each step item
// (s_op = 1) gives one pixel with its coordinates, an on-screen flag, the
// framebuffer address y*screen_width+x (0 when off screen) and the color;
// the last of the max(|dx|,|dy|)+1 pixels carries m_last and ends the line.
// A step item with no line active gives nothing, and a start item replaces a
// line still in progress. Equal |dx| and |dy| are walked y-major. The block
// takes one item every clock cycle: an input register feeds a single pass of
// logic (one add and compare for the walk, one 11x12-bit multiply-add for the
// address at the default coordinate width) into the output register; the input
// and output registers lie between an item and its result on the m_ channel,
// and the only thing that holds the input back is a result left untaken. The
// screen size registers are written through the cfg_ port, always ready; the
// user must write them only while no item is in flight (block does not check).
module bresenham_line_pixel_generator
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [DIM_BITS-1:0]              cfg_data,

    // input item channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic signed [COORD_BITS-1:0]     s_start_x,
    input  logic signed [COORD_BITS-1:0]     s_start_y,
    input  logic signed [COORD_BITS-1:0]     s_end_x,
    input  logic signed [COORD_BITS-1:0]     s_end_y,
    input  logic [COLOR_BITS-1:0]            s_line_color,

    // pixel result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [COORD_BITS-1:0]     m_pixel_x,
    output logic signed [COORD_BITS-1:0]     m_pixel_y,
    output logic                             m_visible,
    output logic [ADDR_BITS-1:0]             m_pixel_address,
    output logic [COLOR_BITS-1:0]            m_pixel_color,
    output logic                             m_last
);

    // error term needs room for 2*major plus sign
    localparam int ERR_BITS  = COORD_BITS + 4;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int CNT_BITS  = COORD_BITS + 1;
    localparam int CMP_BITS  = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
    localparam int PROD_BITS = COORD_BITS - 1 + DIM_BITS;
    localparam int SUM_BITS  = (PROD_BITS + 1 > ADDR_BITS) ? PROD_BITS + 1 : ADDR_BITS;

    // configuration registers
    logic [DIM_BITS-1:0]          screen_width_reg;
    logic [DIM_BITS-1:0]          screen_height_reg;

    // input register stage
    logic                         in_valid_reg, in_valid_next;
    logic                         in_op_reg;
    logic signed [COORD_BITS-1:0] in_x0_reg, in_y0_reg, in_x1_reg, in_y1_reg;
    logic [COLOR_BITS-1:0]        in_color_reg;

    // line walk state
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic                         step_x_neg_reg, step_x_neg_next;
    logic                         step_y_neg_reg, step_y_neg_next;
    logic                         x_major_reg, x_major_next;
    logic signed [ERR_BITS-1:0]   error_term_reg, error_term_next;
    logic signed [ERR_BITS-1:0]   straight_inc_reg, straight_inc_next;
    logic signed [ERR_BITS-1:0]   diagonal_inc_reg, diagonal_inc_next;
    logic [CNT_BITS-1:0]          pixels_left_reg, pixels_left_next;
    logic [COLOR_BITS-1:0]        held_color_reg, held_color_next;
    logic                         line_active_reg, line_active_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                         out_visible_reg;
    logic [ADDR_BITS-1:0]         out_addr_reg;
    logic [COLOR_BITS-1:0]        out_color_reg;
    logic                         out_last_reg;

    // handshake
    logic                         s_accept;
    logic                         advance;
    logic                         emit;

    // start setup
    logic signed [DIFF_BITS-1:0]  dx, dy, adx_full, ady_full;
    logic [COORD_BITS-1:0]        adx, ady, major, minor;
    logic                         setup_x_major;

    // step datapath
    logic [CNT_BITS-1:0]          pl_dec;
    logic                         fin;
    logic signed [COORD_BITS-1:0] x_stepped, y_stepped;
    logic                         err_negative;
    logic                         vis;
    logic [PROD_BITS-1:0]         prod;
    logic [SUM_BITS-1:0]          addr_sum;
    logic [ADDR_BITS-1:0]         addr;

    // the input stage moves on whenever the output register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign emit      = (in_op_reg == OP_STEP) && line_active_reg;

    assign in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    // start item: deltas, octant and error setup
    always_comb begin
        dx       = DIFF_BITS'(in_x1_reg) - DIFF_BITS'(in_x0_reg);
        dy       = DIFF_BITS'(in_y1_reg) - DIFF_BITS'(in_y0_reg);
        adx_full = dx[DIFF_BITS-1] ? -dx : dx;
        ady_full = dy[DIFF_BITS-1] ? -dy : dy;
        adx      = adx_full[COORD_BITS-1:0];
        ady      = ady_full[COORD_BITS-1:0];
        // ties walk y-major
        setup_x_major = adx > ady;
        major = setup_x_major ? adx : ady;
        minor = setup_x_major ? ady : adx;
    end

    // step item: pixel report and the next walk position
    always_comb begin
        pl_dec       = pixels_left_reg - CNT_BITS'(1);
        fin          = (pl_dec == '0);
        x_stepped    = step_x_neg_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
        y_stepped    = step_y_neg_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1);
        err_negative = error_term_reg[ERR_BITS-1];

        // bounds: both coordinates non-negative and below the screen size
        vis = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1] &&
              (CMP_BITS'($unsigned(cur_x_reg)) < CMP_BITS'(screen_width_reg)) &&
              (CMP_BITS'($unsigned(cur_y_reg)) < CMP_BITS'(screen_height_reg));

        // row stride multiply-add, wraps to the address width
        prod     = PROD_BITS'(cur_y_reg[COORD_BITS-2:0]) * PROD_BITS'(screen_width_reg);
        addr_sum = SUM_BITS'(prod) + SUM_BITS'(cur_x_reg[COORD_BITS-2:0]);
        addr     = vis ? addr_sum[ADDR_BITS-1:0] : '0;
    end

    // walk state next values
    always_comb begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        step_x_neg_next   = step_x_neg_reg;
        step_y_neg_next   = step_y_neg_reg;
        x_major_next      = x_major_reg;
        error_term_next   = error_term_reg;
        straight_inc_next = straight_inc_reg;
        diagonal_inc_next = diagonal_inc_reg;
        pixels_left_next  = pixels_left_reg;
        held_color_next   = held_color_reg;
        line_active_next  = line_active_reg;

        if (advance) begin
            if (in_op_reg == OP_START) begin
                cur_x_next        = in_x0_reg;
                cur_y_next        = in_y0_reg;
                step_x_neg_next   = dx[DIFF_BITS-1];
                step_y_neg_next   = dy[DIFF_BITS-1];
                x_major_next      = setup_x_major;
                error_term_next   = ERR_BITS'(major) - (ERR_BITS'(minor) << 1);
                straight_inc_next = '0 - (ERR_BITS'(minor) << 1);
                diagonal_inc_next = (ERR_BITS'(major) << 1) - (ERR_BITS'(minor) << 1);
                pixels_left_next  = CNT_BITS'(major) + CNT_BITS'(1);
                held_color_next   = in_color_reg;
                line_active_next  = 1'b1;
            end else if (line_active_reg) begin
                pixels_left_next = pl_dec;
                if (fin) begin
                    line_active_next = 1'b0;
                end else begin
                    // major axis always steps, minor axis on a negative error
                    if (x_major_reg || err_negative) begin
                        cur_x_next = x_stepped;
                    end
                    if (!x_major_reg || err_negative) begin
                        cur_y_next = y_stepped;
                    end
                    error_term_next = err_negative ? error_term_reg + diagonal_inc_reg
                                                   : error_term_reg + straight_inc_reg;
                end
            end
        end
    end

    // output register holds a result until it is taken
    always_comb begin
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            line_active_reg   <= 1'b0;
            screen_width_reg  <= RESET_SCREEN_WIDTH;
            screen_height_reg <= RESET_SCREEN_HEIGHT;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            line_active_reg <= line_active_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_SCREEN_WIDTH: begin
                        screen_width_reg <= cfg_data;
                    end
                    REG_SCREEN_HEIGHT: begin
                        screen_height_reg <= cfg_data;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg    <= s_op;
            in_x0_reg    <= s_start_x;
            in_y0_reg    <= s_start_y;
            in_x1_reg    <= s_end_x;
            in_y1_reg    <= s_end_y;
            in_color_reg <= s_line_color;
        end

        cur_x_reg        <= cur_x_next;
        cur_y_reg        <= cur_y_next;
        step_x_neg_reg   <= step_x_neg_next;
        step_y_neg_reg   <= step_y_neg_next;
        x_major_reg      <= x_major_next;
        error_term_reg   <= error_term_next;
        straight_inc_reg <= straight_inc_next;
        diagonal_inc_reg <= diagonal_inc_next;
        pixels_left_reg  <= pixels_left_next;
        held_color_reg   <= held_color_next;

        if (advance && emit) begin
            out_x_reg       <= cur_x_reg;
            out_y_reg       <= cur_y_reg;
            out_visible_reg <= vis;
            out_addr_reg    <= addr;
            out_color_reg   <= held_color_reg;
            out_last_reg    <= fin;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_x       = out_x_reg;
    assign m_pixel_y       = out_y_reg;
    assign m_visible       = out_visible_reg;
    assign m_pixel_address = out_addr_reg;
    assign m_pixel_color   = out_color_reg;
    assign m_last          = out_last_reg;

endmodule

// ===== src/blpg_checker.sv =====
// port-level checker for the line generator, bound to the top level
`include "bresenham_line_pixel_generator_assert.svh"

module blpg_checker
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_op,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [COORD_BITS-1:0] m_pixel_x,
    input logic signed [COORD_BITS-1:0] m_pixel_y,
    input logic                         m_visible,
    input logic [ADDR_BITS-1:0]         m_pixel_address,
    input logic                         m_last
);

    // a stalled pixel keeps its coordinates, address and last flag
    `BLPG_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_pixel_x) && $stable(m_pixel_y) && $stable(m_pixel_address) && $stable(m_last), "stalled pixel changed")

    // off-screen pixels carry a zero address
    `BLPG_ASSERT(a_offscreen_addr, (m_valid && !m_visible) |-> (m_pixel_address == '0), "off-screen pixel with nonzero address")

    // visible pixels have non-negative coordinates
    `BLPG_ASSERT(a_visible_coords, (m_valid && m_visible) |-> (!m_pixel_x[COORD_BITS-1] && !m_pixel_y[COORD_BITS-1]), "visible pixel with negative coordinate")

    // a fresh pixel always comes from an accepted step item, via the input register
    `BLPG_ASSERT(a_pixel_from_step, $rose(m_valid) |-> $past(s_valid && s_ready && (s_op == OP_STEP), 2), "pixel without a step item")

endmodule

bind bresenham_line_pixel_generator blpg_checker #(.COORD_BITS(COORD_BITS)) u_blpg_checker (.*);

// ===== verif/tb.sv =====
// testbench for the bresenham line pixel generator: predicts every pixel of each line and checks the result stream
`timescale 1ns / 1ps

module tb;
    import blpg_pkg::*;

    localparam int CB          = DEFAULT_COORD_BITS;
    localparam int SETTLE      = 4;      // cycles for an item in flight to drain
    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake before giving up

    // one predicted pixel
    typedef struct {
        logic signed [CB-1:0]    x;
        logic signed [CB-1:0]    y;
        logic                    visible;
        logic [ADDR_BITS-1:0]    address;
        logic [COLOR_BITS-1:0]   color;
        logic                    last;
    } line_pixel_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // block inputs, all known from time zero
    logic                        cfg_valid    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index    = '0;
    logic [DIM_BITS-1:0]         cfg_data     = '0;
    logic                        s_valid      = 1'b0;
    logic                        s_op         = OP_START;
    logic signed [CB-1:0]        s_start_x    = '0;
    logic signed [CB-1:0]        s_start_y    = '0;
    logic signed [CB-1:0]        s_end_x      = '0;
    logic signed [CB-1:0]        s_end_y      = '0;
    logic [COLOR_BITS-1:0]       s_line_color = '0;
    logic                        m_ready      = 1'b0;

    // block outputs
    logic                        cfg_ready;
    logic                        s_ready;
    logic                        m_valid;
    logic signed [CB-1:0]        m_pixel_x;
    logic signed [CB-1:0]        m_pixel_y;
    logic                        m_visible;
    logic [ADDR_BITS-1:0]        m_pixel_address;
    logic [COLOR_BITS-1:0]       m_pixel_color;
    logic                        m_last;

    bresenham_line_pixel_generator #(
        .COORD_BITS (CB)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_start_x       (s_start_x),
        .s_start_y       (s_start_y),
        .s_end_x         (s_end_x),
        .s_end_y         (s_end_y),
        .s_line_color    (s_line_color),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_visible       (m_visible),
        .m_pixel_address (m_pixel_address),
        .m_pixel_color   (m_pixel_color),
        .m_last          (m_last)
    );

    // ------------------------------------------------------------------
    // line walker model: its own copy of the screen size and walk state
    // ------------------------------------------------------------------
    logic [DIM_BITS-1:0]     screen_w = RESET_SCREEN_WIDTH;
    logic [DIM_BITS-1:0]     screen_h = RESET_SCREEN_HEIGHT;
    int                      walk_x, walk_y;
    logic                    neg_x, neg_y, x_major;
    int                      err_acc, inc_straight, inc_diag;
    int                      pixels_togo;
    logic [COLOR_BITS-1:0]   held_color;
    logic                    line_on;

    line_pixel_t expected_pixels[$];

    int fail_count    = 0;
    int items_done    = 0;
    int burst_left    = 0;
    bit steady_sender = 1'b0;

    // zero start state; the block resets only its line-active flag among these
    initial begin
        walk_x       = 0;
        walk_y       = 0;
        neg_x        = 1'b0;
        neg_y        = 1'b0;
        x_major      = 1'b0;
        err_acc      = 0;
        inc_straight = 0;
        inc_diag     = 0;
        pixels_togo  = 0;
        held_color   = '0;
        line_on      = 1'b0;
    end

    // apply one accepted item to the walker; a step pushes the pixel it yields
    function automatic void walk_line_item(
        input logic                    op,
        input logic signed [CB-1:0]    x0,
        input logic signed [CB-1:0]    y0,
        input logic signed [CB-1:0]    x1,
        input logic signed [CB-1:0]    y1,
        input logic [COLOR_BITS-1:0]   color
    );
        int          dx, dy, major, minor, w, h;
        line_pixel_t px;
        if (op == OP_START) begin
            dx    = int'(x1) - int'(x0);
            dy    = int'(y1) - int'(y0);
            neg_x = dx < 0;
            neg_y = dy < 0;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            // ties go y-major
            x_major      = dx > dy;
            major        = x_major ? dx : dy;
            minor        = x_major ? dy : dx;
            err_acc      = major - 2 * minor;
            inc_straight = -2 * minor;
            inc_diag     = 2 * major - 2 * minor;
            pixels_togo  = major + 1;
            walk_x       = int'(x0);
            walk_y       = int'(y0);
            held_color   = color;
            line_on      = 1'b1;
            return;
        end
        // step with no line gives nothing
        if (!line_on) return;
        w          = screen_w;
        h          = screen_h;
        px.x       = CB'(walk_x);
        px.y       = CB'(walk_y);
        px.visible = walk_x >= 0 && walk_y >= 0 && walk_x < w && walk_y < h;
        px.address = px.visible ? ADDR_BITS'(walk_y * w + walk_x) : '0;
        px.color   = held_color;
        pixels_togo--;
        px.last    = pixels_togo == 0;
        expected_pixels.push_back(px);
        if (px.last) begin
            line_on = 1'b0;
            return;
        end
        if (x_major) begin
            walk_x += neg_x ? -1 : 1;
            if (err_acc < 0) begin
                walk_y  += neg_y ? -1 : 1;
                err_acc += inc_diag;
            end else begin
                err_acc += inc_straight;
            end
        end else begin
            walk_y += neg_y ? -1 : 1;
            if (err_acc < 0) begin
                walk_x  += neg_x ? -1 : 1;
                err_acc += inc_diag;
            end else begin
                err_acc += inc_straight;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // each pixel taken is matched against the oldest prediction
    always @(posedge aclk) begin : pixel_check
        line_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d",
                         $time, m_pixel_x, m_pixel_y);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("pixel_x", want.x, m_pixel_x);
                compare_field("pixel_y", want.y, m_pixel_y);
                compare_field("visible", want.visible, m_visible);
                compare_field("pixel_address", want.address, m_pixel_address);
                compare_field("pixel_color", want.color, m_pixel_color);
                compare_field("last", want.last, m_last);
            end
        end
    end

    // watchdog: too long with no handshake on any channel ends the run
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // result-side backpressure: the stall pattern steps through four modes as rx_cycle counts cycles
    // ------------------------------------------------------------------
    int rx_cycle = 0;
    int rx_hold  = 0;
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            case ((rx_cycle / 97) % 4)
                0: m_ready <= 1'b1;                        // no stalls at all
                1: m_ready <= 1'($urandom_range(0, 1));    // coin flip per cycle
                2: begin                                   // long stalls, short windows
                    if (m_ready) begin
                        m_ready <= 1'b0;
                        rx_hold = $urandom_range(0, 7);
                    end else begin
                        m_ready <= 1'b1;
                        rx_hold = $urandom_range(0, 3);
                    end
                end
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // send one item in bursts with random gaps, then walk the model on acceptance
    task automatic send_item(
        input logic                    op,
        input logic signed [CB-1:0]    x0,
        input logic signed [CB-1:0]    y0,
        input logic signed [CB-1:0]    x1,
        input logic signed [CB-1:0]    y1,
        input logic [COLOR_BITS-1:0]   color
    );
        int gap;
        // steps past the end of a line are ignored and not counted
        if (op == OP_START || line_on) items_done++;
        if (!steady_sender && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_op         <= op;
        s_start_x    <= x0;
        s_start_y    <= y0;
        s_end_x      <= x1;
        s_end_y      <= y1;
        s_line_color <= color;
        do @(posedge aclk); while (!s_ready);
        walk_line_item(op, x0, y0, x1, y1, color);
    endtask

    // step items carry random endpoint and color fields, which the block ignores
    task automatic pull_pixels(input int n);
        repeat (n) send_item(OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom),
                             CB'($urandom), $urandom);
    endtask

    task automatic start_line(input int x0, input int y0, input int x1, input int y1,
                              input logic [COLOR_BITS-1:0] color);
        send_item(OP_START, CB'(x0), CB'(y0), CB'(x1), CB'(y1), color);
    endtask

    // stop sending and let every predicted pixel drain plus the pipeline depth
    task automatic drain_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // register write, only ever issued with the block drained
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [DIM_BITS-1:0] value);
        drain_block();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_SCREEN_WIDTH) screen_w = value;
        else if (idx == REG_SCREEN_HEIGHT) screen_h = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_screen(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    // keep a coordinate inside the signed field
    function automatic int fit_coord(input int v);
        if (v > 2047) return 2047;
        if (v < -2048) return -2048;
        return v;
    endfunction

    // a point near the visible area, a little off each edge too
    function automatic int near_screen(input logic [DIM_BITS-1:0] dim);
        int span, v;
        span = (dim == 0) ? 2047 : dim;
        v = $urandom_range(0, span + 16);
        v -= 8;
        return fit_coord(v);
    endfunction

    function automatic logic [DIM_BITS-1:0] pick_dim();
        case ($urandom_range(0, 5))
            0:       return DIM_BITS'($urandom);
            1:       return DIM_BITS'($urandom_range(1, 64));
            2:       return '1;
            3:       return '0;
            default: return DIM_BITS'($urandom_range(100, 1024));
        endcase
    endfunction

    // one random sequence: usually a whole short line, sometimes cut short,
    // sometimes a wild line over the full coordinate range, sometimes noise
    task automatic random_line();
        int                    kind, reach, n;
        int                    x0, y0, x1, y1;
        logic [COLOR_BITS-1:0] color;
        kind  = $urandom_range(0, 99);
        color = $urandom;
        n     = -1;
        if (kind < 6 && !line_on) begin
            pull_pixels(1);
            return;
        end
        if (kind < 20) begin
            // full range endpoints, only a few pixels taken before the next start
            x0 = $urandom_range(0, 4095);
            y0 = $urandom_range(0, 4095);
            x1 = $urandom_range(0, 4095);
            y1 = $urandom_range(0, 4095);
            x0 -= 2048;
            y0 -= 2048;
            x1 -= 2048;
            y1 -= 2048;
            n = $urandom_range(0, 6);
        end else begin
            reach = (kind < 24) ? 300 : 20;
            x0 = near_screen(screen_w);
            y0 = near_screen(screen_h);
            x1 = $urandom_range(0, 2 * reach);
            y1 = $urandom_range(0, 2 * reach);
            x1 = fit_coord(x0 + x1 - reach);
            y1 = fit_coord(y0 + y1 - reach);
        end
        start_line(x0, y0, x1, y1, color);
        if (n < 0) begin
            // mostly to the end, with an occasional extra step past it
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, pixels_togo)
                                             : pixels_togo + $urandom_range(0, 1);
        end
        pull_pixels(n);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a step right after reset, with no line loaded, gives nothing
    task automatic test_step_without_line();
        pull_pixels(1);
    endtask

    // equal endpoints give one pixel marked last; the next step is ignored
    task automatic test_single_pixel();
        start_line(100, 50, 100, 50, 32'h0000_0000);
        pull_pixels(2);
    endtask

    // exact diagonal walks y-major, a steep line, a shallow line going back
    task automatic test_line_shapes();
        start_line(2, 2, 5, -1, 32'h1234_5678);
        pull_pixels(4);
        start_line(0, 0, 1, 3, 32'h8000_0001);
        pull_pixels(4);
        start_line(7, 3, 2, 1, 32'h00ff_ff00);
        pull_pixels(6);
    endtask

    // extreme endpoints, and a start that replaces a line still in progress
    task automatic test_replace_line();
        start_line(-2048, -2048, 2047, 2047, 32'hffff_ffff);
        pull_pixels(1);
        start_line(2047, 2047, -2048, -2048, 32'h5555_aaaa);
        pull_pixels(2);
    endtask

    // smallest screen, largest screen with address wrap, zero size
    task automatic test_screen_extremes();
        set_screen(DIM_BITS'(1), DIM_BITS'(1));
        start_line(-1, 0, 1, 0, 32'hdead_beef);
        pull_pixels(3);
        set_screen('1, '1);
        start_line(2045, 2047, 2047, 2047, 32'hcafe_f00d);
        pull_pixels(3);
        set_screen('0, '0);
        start_line(0, 0, 0, 1, 32'h0f0f_0f0f);
        pull_pixels(2);
    endtask

    // random phases, each with its own screen size and sender style
    task automatic test_random_lines();
        int target;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0) set_screen(RESET_SCREEN_WIDTH, RESET_SCREEN_HEIGHT);
            else set_screen(pick_dim(), pick_dim());
            steady_sender = ($urandom_range(0, 3) == 0);
            target = items_done + 180;
            while (items_done < target) random_line();
        end
        steady_sender = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_step_without_line();
        test_single_pixel();
        test_line_shapes();
        test_replace_line();
        test_screen_extremes();
        test_random_lines();

        // all pixels in, then a further wait to catch anything extra
        drain_block();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
